FILE: sv/fhse_pkg.sv
// Shared constants, types and saturating helpers for the face Hencky energy pipeline.
package fhse_pkg;

    localparam int NUM_W      = 64;
    localparam int DEN_W      = 33;
    localparam int DIV_QBITS  = 47;
    localparam int DIV_STEP   = 4;
    localparam int DIV_STAGES = (DIV_QBITS + DIV_STEP - 1) / DIV_STEP;
    localparam int MUL_LAT    = 3;

    // pipeline stage numbers, stage 0 is the input register
    localparam int T_DIV_IN = 1;
    localparam int T_RATIO  = T_DIV_IN + DIV_STAGES + 1;
    localparam int T_SQ     = T_RATIO + MUL_LAT;
    localparam int T_T      = T_SQ + 1;
    localparam int T_P      = T_SQ + MUL_LAT;
    localparam int T_M      = T_P + MUL_LAT;
    localparam int T_VP     = T_M + MUL_LAT;
    localparam int T_V      = T_VP + 1;
    localparam int T_EP     = T_V + MUL_LAT;
    localparam int T_OUT    = T_EP + 1;

    localparam logic [DIV_QBITS-1:0] RATIO_MAX = '1;
    localparam logic [63:0] INT64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] INT64_MIN = 64'h8000_0000_0000_0000;
    localparam logic [63:0] NEG_TWO_Q32 = 64'hFFFF_FFFE_0000_0000;

    // ratio indexes: rij, rjk, rki, ri, rj, rk
    localparam int R_IJ = 0;
    localparam int R_JK = 1;
    localparam int R_KI = 2;
    localparam int R_I  = 3;
    localparam int R_J  = 4;
    localparam int R_K  = 5;

    // matrix entry order: m00, m11, m22, m02, m01, m12; row-major map
    localparam int MAT_SEL [9] = '{0, 4, 3, 4, 1, 5, 3, 5, 2};

    typedef struct packed {
        logic [63:0] val;
        logic        clip;
    } sat_t;

    function automatic sat_t sat_add(logic [63:0] a, logic [63:0] b);
        sat_t        r;
        logic [63:0] s;
        s = a + b;
        r.clip = (a[63] == b[63]) && (s[63] != a[63]);
        r.val  = r.clip ? (a[63] ? INT64_MIN : INT64_MAX) : s;
        return r;
    endfunction

    function automatic sat_t sat_x4(logic [63:0] x);
        sat_t r;
        r.clip = !((x[63:61] == 3'b000) || (x[63:61] == 3'b111));
        r.val  = r.clip ? (x[63] ? INT64_MIN : INT64_MAX) : {x[61:0], 2'b00};
        return r;
    endfunction

    function automatic logic [63:0] q16_to_q32(logic [31:0] v);
        return {{16{v[31]}}, v, 16'b0};
    endfunction

endpackage

FILE: sv/fhse_if.sv
// Valid/ready channels for face beats and energy result beats.
interface fhse_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] area;
    logic [31:0] len_ij;
    logic [31:0] len_jk;
    logic [31:0] len_ki;
    logic signed [31:0] cot_i;
    logic signed [31:0] cot_j;
    logic signed [31:0] cot_k;
    logic signed [31:0] dll_ij;
    logic signed [31:0] dll_jk;
    logic signed [31:0] dll_ki;

    modport source (output valid, area, len_ij, len_jk, len_ki, cot_i, cot_j, cot_k,
                    dll_ij, dll_jk, dll_ki, input ready);
    modport sink (input valid, area, len_ij, len_jk, len_ki, cot_i, cot_j, cot_k,
                  dll_ij, dll_jk, dll_ki, output ready);
endinterface

interface fhse_out_if;
    logic        valid;
    logic        ready;
    logic signed [63:0] energy;
    logic        degenerate;
    logic        saturated;

    modport source (output valid, energy, degenerate, saturated, input ready);
    modport sink (input valid, energy, degenerate, saturated, output ready);
endinterface

FILE: sv/face_hencky_strain_energy.sv
// Top level of the per-face Hencky strain energy pipeline.
// Takes one face beat per cycle while the result beat is not held, and returns energies in order.
// The path is set by six 12-stage dividers forming the length ratios, then a chain of
// pipelined 64-bit saturating multipliers (squares, area scale, matrix entries, M*d, d.v).
// When the result beat is held, the whole pipeline holds; ready drops only while the output
// register is full and not taken. Zero area returns energy 0 with degenerate set.
module face_hencky_strain_energy (
    input  logic        clk,
    input  logic        rst_n,
    fhse_in_if.sink     face,
    fhse_out_if.source  result
);

    localparam int TO = fhse_pkg::T_OUT;

    logic en;

    logic        vld_reg  [0:TO];
    logic        zero_reg [0:TO];
    logic        clp_reg  [0:TO];
    logic        clp_next [0:TO];

    logic [31:0] area_reg [0:fhse_pkg::T_SQ];
    logic [31:0] lij_reg;
    logic [31:0] ljk_reg;
    logic [31:0] lki_reg;
    logic [31:0] cot_reg  [0:fhse_pkg::T_SQ-1][0:2];
    logic [31:0] dll_reg  [0:fhse_pkg::T_V][0:2];
    logic [63:0] prod_reg [0:5];
    logic [63:0] cx_reg   [0:2];
    logic [63:0] t_reg    [fhse_pkg::T_T:fhse_pkg::T_P][0:5];
    logic [63:0] t_next   [0:5];
    logic [63:0] v_reg    [0:2];
    logic [63:0] v_next   [0:2];
    logic [63:0] energy_reg;
    logic [63:0] energy_next;
    logic        tclip;
    logic        vclip;
    logic        eclip;

    logic [fhse_pkg::DIV_QBITS-1:0] q_w [0:5];
    logic [63:0] ratio_w [0:5];
    logic [63:0] sq_w    [0:5];
    logic [63:0] p_w     [0:5];
    logic [63:0] m_w     [0:5];
    logic [63:0] vp_w    [0:8];
    logic [63:0] ep_w    [0:2];
    logic [5:0]  dclip_w;
    logic [5:0]  sqc_w;
    logic [5:0]  pc_w;
    logic [5:0]  mc_w;
    logic [8:0]  vpc_w;
    logic [2:0]  epc_w;

    assign en         = !vld_reg[TO] || result.ready;
    assign face.ready = en;

    genvar n, i, j;
    generate
        for (n = 0; n < 6; n++)
        begin : g_ent
            fhse_div u_div (
                .clk  (clk),
                .en   (en),
                .num  (prod_reg[n]),
                .den  ({area_reg[fhse_pkg::T_DIV_IN], 1'b0}),
                .q    (q_w[n]),
                .clip (dclip_w[n])
            );
            assign ratio_w[n] = {1'b0, q_w[n], 16'b0};

            fhse_mul u_sq (
                .clk (clk), .en (en), .a (ratio_w[n]), .b (ratio_w[n]),
                .p (sq_w[n]), .clip (sqc_w[n])
            );
            fhse_mul u_area (
                .clk (clk), .en (en), .a ({16'b0, area_reg[fhse_pkg::T_SQ], 16'b0}),
                .b (sq_w[n]), .p (p_w[n]), .clip (pc_w[n])
            );
            fhse_mul u_m (
                .clk (clk), .en (en), .a (p_w[n]), .b (t_reg[fhse_pkg::T_P][n]),
                .p (m_w[n]), .clip (mc_w[n])
            );
        end
        for (i = 0; i < 3; i++)
        begin : g_row
            for (j = 0; j < 3; j++)
            begin : g_col
                fhse_mul u_vp (
                    .clk (clk), .en (en), .a (m_w[fhse_pkg::MAT_SEL[i*3+j]]),
                    .b (fhse_pkg::q16_to_q32(dll_reg[fhse_pkg::T_M][j])),
                    .p (vp_w[i*3+j]), .clip (vpc_w[i*3+j])
                );
            end
            fhse_mul u_ep (
                .clk (clk), .en (en), .a (fhse_pkg::q16_to_q32(dll_reg[fhse_pkg::T_V][i])),
                .b (v_reg[i]), .p (ep_w[i]), .clip (epc_w[i])
            );
        end
    endgenerate

    // t = 4*x - 2 for each matrix entry
    always_comb
    begin
        fhse_pkg::sat_t f;
        fhse_pkg::sat_t s;
        logic [63:0]    x;
        tclip = 1'b0;
        for (int e = 0; e < 6; e++)
        begin
            case (e)
                0:       x = sq_w[fhse_pkg::R_K];
                1:       x = sq_w[fhse_pkg::R_I];
                2:       x = sq_w[fhse_pkg::R_J];
                default: x = cx_reg[e-3];
            endcase
            f = fhse_pkg::sat_x4(x);
            s = fhse_pkg::sat_add(f.val, fhse_pkg::NEG_TWO_Q32);
            t_next[e] = s.val;
            tclip = tclip | f.clip | s.clip;
        end
    end

    always_comb
    begin
        fhse_pkg::sat_t s1;
        fhse_pkg::sat_t s2;
        vclip = 1'b0;
        for (int r = 0; r < 3; r++)
        begin
            s1 = fhse_pkg::sat_add(vp_w[r*3], vp_w[r*3+1]);
            s2 = fhse_pkg::sat_add(s1.val, vp_w[r*3+2]);
            v_next[r] = s2.val;
            vclip = vclip | s1.clip | s2.clip;
        end
    end

    always_comb
    begin
        fhse_pkg::sat_t s1;
        fhse_pkg::sat_t s2;
        s1 = fhse_pkg::sat_add(ep_w[0], ep_w[1]);
        s2 = fhse_pkg::sat_add(s1.val, ep_w[2]);
        eclip = s1.clip | s2.clip;
        energy_next = zero_reg[TO-1] ? 64'd0 : s2.val;
    end

    // sticky clip flag; a unit's clip output sits beside its item's stage and joins
    // the flag as that item moves one stage on
    always_comb
    begin
        clp_next[0] = 1'b0;
        for (int t = 1; t < TO; t++)
        begin
            clp_next[t] = clp_reg[t-1];
        end
        clp_next[fhse_pkg::T_RATIO+1] = clp_reg[fhse_pkg::T_RATIO] | (|dclip_w);
        clp_next[fhse_pkg::T_T]       = clp_reg[fhse_pkg::T_SQ] | (|sqc_w) | tclip;
        clp_next[fhse_pkg::T_P+1]     = clp_reg[fhse_pkg::T_P] | (|pc_w);
        clp_next[fhse_pkg::T_M+1]     = clp_reg[fhse_pkg::T_M] | (|mc_w);
        clp_next[fhse_pkg::T_V]       = clp_reg[fhse_pkg::T_VP] | (|vpc_w) | vclip;
        clp_next[TO] = !zero_reg[TO-1]
                       && (clp_reg[fhse_pkg::T_EP] | (|epc_w) | eclip);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t <= TO; t++)
            begin
                vld_reg[t] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= face.valid;
            for (int t = 1; t <= TO; t++)
            begin
                vld_reg[t] <= vld_reg[t-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg[0] <= (face.area == 32'd0);
            clp_reg[0]  <= clp_next[0];
            for (int t = 1; t <= TO; t++)
            begin
                zero_reg[t] <= zero_reg[t-1];
                clp_reg[t]  <= clp_next[t];
            end

            area_reg[0] <= face.area;
            for (int t = 1; t <= fhse_pkg::T_SQ; t++)
            begin
                area_reg[t] <= area_reg[t-1];
            end
            lij_reg <= face.len_ij;
            ljk_reg <= face.len_jk;
            lki_reg <= face.len_ki;
            cot_reg[0][0] <= face.cot_i;
            cot_reg[0][1] <= face.cot_j;
            cot_reg[0][2] <= face.cot_k;
            dll_reg[0][0] <= face.dll_ij;
            dll_reg[0][1] <= face.dll_jk;
            dll_reg[0][2] <= face.dll_ki;
            for (int t = 1; t < fhse_pkg::T_SQ; t++)
            begin
                cot_reg[t] <= cot_reg[t-1];
            end
            for (int t = 1; t <= fhse_pkg::T_V; t++)
            begin
                dll_reg[t] <= dll_reg[t-1];
            end

            prod_reg[fhse_pkg::R_IJ] <= lij_reg * lij_reg;
            prod_reg[fhse_pkg::R_JK] <= ljk_reg * ljk_reg;
            prod_reg[fhse_pkg::R_KI] <= lki_reg * lki_reg;
            prod_reg[fhse_pkg::R_I]  <= lij_reg * lki_reg;
            prod_reg[fhse_pkg::R_J]  <= ljk_reg * lij_reg;
            prod_reg[fhse_pkg::R_K]  <= lki_reg * ljk_reg;

            // cot_j*cot_k, cot_k*cot_i, cot_i*cot_j
            cx_reg[0] <= 64'($signed(cot_reg[fhse_pkg::T_SQ-1][1])
                           * $signed(cot_reg[fhse_pkg::T_SQ-1][2]));
            cx_reg[1] <= 64'($signed(cot_reg[fhse_pkg::T_SQ-1][2])
                           * $signed(cot_reg[fhse_pkg::T_SQ-1][0]));
            cx_reg[2] <= 64'($signed(cot_reg[fhse_pkg::T_SQ-1][0])
                           * $signed(cot_reg[fhse_pkg::T_SQ-1][1]));

            t_reg[fhse_pkg::T_T] <= t_next;
            for (int t = fhse_pkg::T_T + 1; t <= fhse_pkg::T_P; t++)
            begin
                t_reg[t] <= t_reg[t-1];
            end

            v_reg      <= v_next;
            energy_reg <= energy_next;
        end
    end

    assign result.valid      = vld_reg[TO];
    assign result.energy     = energy_reg;
    assign result.degenerate = zero_reg[TO];
    assign result.saturated  = clp_reg[TO];

endmodule

FILE: sv/fhse_div.sv
// Pipelined restoring divider: floor(num/den) clipped to 47 bits, up to 4 quotient bits per stage.
module fhse_div (
    input  logic                           clk,
    input  logic                           en,
    input  logic [fhse_pkg::NUM_W-1:0]     num,
    input  logic [fhse_pkg::DEN_W-1:0]     den,
    output logic [fhse_pkg::DIV_QBITS-1:0] q,
    output logic                           clip
);

    logic [fhse_pkg::DEN_W-1:0]     rem_reg  [0:fhse_pkg::DIV_STAGES];
    logic [fhse_pkg::DEN_W-1:0]     den_reg  [0:fhse_pkg::DIV_STAGES];
    logic [fhse_pkg::DIV_QBITS-1:0] num_reg  [0:fhse_pkg::DIV_STAGES];
    logic [fhse_pkg::DIV_QBITS-1:0] q_reg    [0:fhse_pkg::DIV_STAGES];
    logic                           clip_reg [0:fhse_pkg::DIV_STAGES];

    logic [fhse_pkg::DEN_W-1:0]     rem_next [1:fhse_pkg::DIV_STAGES];
    logic [fhse_pkg::DIV_QBITS-1:0] num_next [1:fhse_pkg::DIV_STAGES];
    logic [fhse_pkg::DIV_QBITS-1:0] q_next   [1:fhse_pkg::DIV_STAGES];

    always_comb
    begin
        logic [fhse_pkg::DEN_W:0]       rs;
        logic [fhse_pkg::DEN_W-1:0]     r;
        logic [fhse_pkg::DIV_QBITS-1:0] n;
        logic [fhse_pkg::DIV_QBITS-1:0] qq;
        for (int s = 1; s <= fhse_pkg::DIV_STAGES; s++)
        begin
            r  = rem_reg[s-1];
            n  = num_reg[s-1];
            qq = q_reg[s-1];
            for (int b = 0; b < fhse_pkg::DIV_STEP; b++)
            begin
                if ((s - 1) * fhse_pkg::DIV_STEP + b < fhse_pkg::DIV_QBITS)
                begin
                    rs = {r, n[fhse_pkg::DIV_QBITS-1]};
                    n  = {n[fhse_pkg::DIV_QBITS-2:0], 1'b0};
                    if (rs >= {1'b0, den_reg[s-1]})
                    begin
                        r  = fhse_pkg::DEN_W'(rs - {1'b0, den_reg[s-1]});
                        qq = {qq[fhse_pkg::DIV_QBITS-2:0], 1'b1};
                    end
                    else
                    begin
                        r  = rs[fhse_pkg::DEN_W-1:0];
                        qq = {qq[fhse_pkg::DIV_QBITS-2:0], 1'b0};
                    end
                end
            end
            rem_next[s] = r;
            num_next[s] = n;
            q_next[s]   = qq;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // leading bits never yield quotient bits unless the ratio clips
            rem_reg[0]  <= fhse_pkg::DEN_W'(num[fhse_pkg::NUM_W-1:fhse_pkg::DIV_QBITS]);
            num_reg[0]  <= num[fhse_pkg::DIV_QBITS-1:0];
            q_reg[0]    <= '0;
            den_reg[0]  <= den;
            clip_reg[0] <= fhse_pkg::DEN_W'(num[fhse_pkg::NUM_W-1:fhse_pkg::DIV_QBITS]) >= den;
            for (int s = 1; s <= fhse_pkg::DIV_STAGES; s++)
            begin
                rem_reg[s]  <= rem_next[s];
                num_reg[s]  <= num_next[s];
                q_reg[s]    <= q_next[s];
                den_reg[s]  <= den_reg[s-1];
                clip_reg[s] <= clip_reg[s-1];
            end
        end
    end

    assign clip = clip_reg[fhse_pkg::DIV_STAGES];
    assign q    = clip_reg[fhse_pkg::DIV_STAGES] ? fhse_pkg::RATIO_MAX
                                                 : q_reg[fhse_pkg::DIV_STAGES];

endmodule

FILE: sv/fhse_mul.sv
// Three-stage saturating signed Q32.32 multiplier built from four 32x32 partial products.
module fhse_mul (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic [63:0] p,
    output logic        clip
);

    logic [63:0]  ma_reg;
    logic [63:0]  mb_reg;
    logic         neg_a_reg;
    logic         neg_b_reg;
    logic [63:0]  p00_reg;
    logic [63:0]  p01_reg;
    logic [63:0]  p10_reg;
    logic [63:0]  p11_reg;
    logic [63:0]  p_reg;
    logic         clip_reg;

    logic [127:0] full;
    logic [63:0]  p_next;
    logic         clip_next;

    always_comb
    begin
        full = {64'b0, p00_reg} + {32'b0, p01_reg, 32'b0} + {32'b0, p10_reg, 32'b0}
             + {p11_reg, 64'b0};
        if (!neg_b_reg)
        begin
            clip_next = |full[127:95];
            p_next    = clip_next ? fhse_pkg::INT64_MAX : full[95:32];
        end
        else
        begin
            clip_next = (|full[127:96]) || (full[95] && (|full[94:32]));
            p_next    = clip_next ? fhse_pkg::INT64_MIN : 64'd0 - full[95:32];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ma_reg     <= a[63] ? 64'd0 - a : a;
            mb_reg     <= b[63] ? 64'd0 - b : b;
            neg_a_reg  <= a[63] ^ b[63];
            p00_reg    <= ma_reg[31:0] * mb_reg[31:0];
            p01_reg    <= ma_reg[31:0] * mb_reg[63:32];
            p10_reg    <= ma_reg[63:32] * mb_reg[31:0];
            p11_reg    <= ma_reg[63:32] * mb_reg[63:32];
            neg_b_reg  <= neg_a_reg;
            p_reg      <= p_next;
            clip_reg   <= clip_next;
        end
    end

    assign p    = p_reg;
    assign clip = clip_reg;

endmodule

FILE: sv/fhse_chk.sv
// Port-level checker for the face energy pipeline, bound to the top level.
module fhse_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] energy,
    input logic        degenerate,
    input logic        saturated
);

    // a zero-area face carries no energy and no clip
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> (energy == 64'd0) && !saturated)
        else $error("degenerate beat with nonzero energy or clip");

    // an empty output register never blocks the input side
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled while output empty");

    // a held result leaves the input stalled
    a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input accepted while result held");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(energy)
                                    && $stable(saturated) && $stable(degenerate))
        else $error("held result beat changed");

endmodule

bind face_hencky_strain_energy fhse_chk u_fhse_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (face.ready),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .energy     (result.energy),
    .degenerate (result.degenerate),
    .saturated  (result.saturated)
);

FILE: bench/tb_top.sv
// Testbench for the face Hencky strain energy pipeline: directed table plus random faces.
`timescale 1ns / 100ps

module tb_top;

    typedef struct {
        logic [31:0] area, lij, ljk, lki;
        logic [31:0] ci, cj, ck, dij, djk, dki;
    } face_t;

    typedef struct {
        logic [63:0] energy;
        logic        degen;
        logic        sat;
    } energy_t;

    typedef struct {
        face_t       f;
        logic        typed;
        logic [63:0] energy;
        logic        degen;
        logic        sat;
    } row_t;

    localparam logic [63:0] I64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] I64_MIN = 64'h8000_0000_0000_0000;

    logic clk;
    logic rst_n;

    fhse_in_if  face ();
    fhse_out_if result ();

    face_hencky_strain_energy dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .face   (face),
        .result (result)
    );

    energy_t energy_q[$];
    int      errors;
    int      send_idle_pct;
    int      recv_idle_pct;
    logic    hold_req;
    logic    hold_off;
    logic    clip_flag;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // ---- energy predictor ----
    function automatic logic [63:0] mag(logic [63:0] v);
        return v[63] ? -v : v;
    endfunction

    function automatic logic [63:0] smul(logic [63:0] a, logic [63:0] b, int sh);
        logic          neg;
        logic [127:0]  p;
        logic [127:0]  s;
        neg = a[63] != b[63];
        p   = {64'b0, mag(a)} * {64'b0, mag(b)};
        s   = p >> sh;
        if (!neg)
        begin
            if (s > {64'b0, I64_MAX})
            begin
                clip_flag = 1'b1;
                return I64_MAX;
            end
            return s[63:0];
        end
        if (s > {64'b0, I64_MIN})
        begin
            clip_flag = 1'b1;
            return I64_MIN;
        end
        return -s[63:0];
    endfunction

    function automatic logic [63:0] sadd(logic [63:0] a, logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63])
        begin
            clip_flag = 1'b1;
            return a[63] ? I64_MIN : I64_MAX;
        end
        return s;
    endfunction

    function automatic logic [63:0] len_ratio(logic [31:0] la, logic [31:0] lb,
                                              logic [31:0] area);
        logic [63:0] q;
        q = ({32'b0, la} * {32'b0, lb}) / ({32'b0, area} << 1);
        if (q > 64'h7FFF_FFFF_FFFF)
        begin
            clip_flag = 1'b1;
            q = 64'h7FFF_FFFF_FFFF;
        end
        return q << 16;
    endfunction

    function automatic logic [63:0] mat_entry(logic [63:0] a32, logic [63:0] r,
                                              logic [63:0] x);
        logic [63:0] t, p;
        t = sadd(smul(x, 64'd4, 0), 64'hFFFF_FFFE_0000_0000);
        p = smul(a32, smul(r, r, 32), 32);
        return smul(p, t, 32);
    endfunction

    function automatic energy_t predict_energy(face_t f);
        energy_t     e;
        logic [63:0] d[3], v[3], m[3][3], a32, acc;
        logic [63:0] rij, rjk, rki, ri, rj, rk, ci, cj, ck;
        clip_flag = 1'b0;
        e.degen = 1'b0;
        if (f.area == 0)
        begin
            e.energy = 0;
            e.degen  = 1'b1;
            e.sat    = 1'b0;
            return e;
        end
        d[0] = {{16{f.dij[31]}}, f.dij, 16'b0};
        d[1] = {{16{f.djk[31]}}, f.djk, 16'b0};
        d[2] = {{16{f.dki[31]}}, f.dki, 16'b0};
        ci = {{32{f.ci[31]}}, f.ci};
        cj = {{32{f.cj[31]}}, f.cj};
        ck = {{32{f.ck[31]}}, f.ck};
        a32 = {16'b0, f.area, 16'b0};
        rij = len_ratio(f.lij, f.lij, f.area);
        rjk = len_ratio(f.ljk, f.ljk, f.area);
        rki = len_ratio(f.lki, f.lki, f.area);
        ri  = len_ratio(f.lij, f.lki, f.area);
        rj  = len_ratio(f.ljk, f.lij, f.area);
        rk  = len_ratio(f.lki, f.ljk, f.area);
        m[0][0] = mat_entry(a32, rij, smul(rk, rk, 32));
        m[1][1] = mat_entry(a32, rjk, smul(ri, ri, 32));
        m[2][2] = mat_entry(a32, rki, smul(rj, rj, 32));
        m[0][2] = mat_entry(a32, ri, smul(cj, ck, 0));
        m[2][0] = m[0][2];
        m[0][1] = mat_entry(a32, rj, smul(ck, ci, 0));
        m[1][0] = m[0][1];
        m[1][2] = mat_entry(a32, rk, smul(ci, cj, 0));
        m[2][1] = m[1][2];
        for (int i = 0; i < 3; i++)
        begin
            v[i] = 0;
            for (int j = 0; j < 3; j++)
                v[i] = sadd(v[i], smul(m[i][j], d[j], 32));
        end
        acc = 0;
        for (int i = 0; i < 3; i++)
            acc = sadd(acc, smul(d[i], v[i], 32));
        e.energy = acc;
        e.sat    = clip_flag;
        return e;
    endfunction

    // ---- driving ----
    // valid stays up after a beat; an idle gap in the next call or an explicit drop lowers it
    task automatic send_face(input face_t f);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            face.valid <= 1'b0;
            @(negedge clk);
        end
        face.valid  <= 1'b1;
        face.area   <= f.area;
        face.len_ij <= f.lij;
        face.len_jk <= f.ljk;
        face.len_ki <= f.lki;
        face.cot_i  <= f.ci;
        face.cot_j  <= f.cj;
        face.cot_k  <= f.ck;
        face.dll_ij <= f.dij;
        face.dll_jk <= f.djk;
        face.dll_ki <= f.dki;
        @(posedge clk);
        while (!face.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic push_expect(input face_t f, input logic typed, input energy_t want);
        energy_t e;
        e = predict_energy(f);
        if (typed && (e.energy !== want.energy || e.degen !== want.degen
                      || e.sat !== want.sat))
            report("table row vs predictor", e.energy, want.energy);
        energy_q.insert(energy_q.size(), e);
    endtask

    function automatic logic [31:0] rnd_len();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(32'h0004_0000);
            default: return $urandom_range(32'h0000_8000, 32'h0003_0000);
        endcase
    endfunction

    function automatic logic [31:0] rnd_small_s();
        case ($urandom_range(3))
            0: return $urandom;
            default: return $urandom_range(32'h0002_0000) - 32'h0001_0000;
        endcase
    endfunction

    function automatic face_t rnd_face();
        face_t f;
        case ($urandom_range(9))
            0: f.area = 0;
            1: f.area = $urandom;
            2: f.area = $urandom_range(15, 1);
            default: f.area = $urandom_range(32'h0002_0000, 32'h0000_2000);
        endcase
        f.lij = rnd_len();
        f.ljk = rnd_len();
        f.lki = rnd_len();
        f.ci  = rnd_small_s();
        f.cj  = rnd_small_s();
        f.ck  = rnd_small_s();
        f.dij = rnd_small_s();
        f.djk = rnd_small_s();
        f.dki = rnd_small_s();
        return f;
    endfunction

    // ---- receiver ----
    initial
    begin
        result.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off)
                result.ready <= 1'b0;
            else
                result.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // long receiver hold-off, counted here once requested
    initial
    begin
        hold_off = 1'b0;
        wait (hold_req === 1'b1);
        @(negedge clk);
        hold_off <= 1'b1;
        repeat (120) @(negedge clk);
        hold_off <= 1'b0;
    end

    always @(posedge clk)
    begin
        energy_t want;
        if (rst_n && result.valid && result.ready)
        begin
            if (energy_q.size() == 0)
            begin
                report("unexpected result beat", result.energy, 64'd0);
            end
            else
            begin
                want = energy_q.pop_front();
                if (result.energy !== want.energy)
                    report("energy", result.energy, want.energy);
                if (result.degenerate !== want.degen)
                    report("degenerate", 64'(result.degenerate), 64'(want.degen));
                if (result.saturated !== want.sat)
                    report("saturated", 64'(result.saturated), 64'(want.sat));
            end
        end
    end

    // ---- main sequence ----
    initial
    begin
        row_t    tbl[$];
        row_t    r;
        face_t   f;
        energy_t want;
        int      guard;

        errors        = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req      = 1'b0;
        rst_n         = 1'b0;
        face.valid    = 1'b0;
        face.area = 0; face.len_ij = 0; face.len_jk = 0; face.len_ki = 0;
        face.cot_i = 0; face.cot_j = 0; face.cot_k = 0;
        face.dll_ij = 0; face.dll_jk = 0; face.dll_ki = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed rows; typed expectations only where obvious
        r.typed = 1'b1; r.energy = 0; r.degen = 1'b1; r.sat = 1'b0;
        r.f = '{32'h0, '1, '1, '1, 32'h7FFF_FFFF, 32'h8000_0000, '1,
                32'h7FFF_FFFF, 32'h8000_0000, 32'h1};
        tbl.insert(tbl.size(), r);
        r.f = '{32'h0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
        tbl.insert(tbl.size(), r);
        // zero change vector: energy 0, no clipping
        r.degen = 1'b0;
        r.f = '{32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                32'h0000_93CD, 32'h0000_93CD, 32'h0000_93CD, 0, 0, 0};
        tbl.insert(tbl.size(), r);
        r.typed = 1'b0;
        r.f = '{32'h0000_6ED9, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                32'h0000_93CD, 32'h0000_93CD, 32'h0000_93CD,
                32'h0000_1000, 32'hFFFF_F000, 32'h0000_0800};
        tbl.insert(tbl.size(), r);
        r.f = '{32'h1, '1, '1, '1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        tbl.insert(tbl.size(), r);
        r.f = '{'1, '1, '1, '1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        tbl.insert(tbl.size(), r);
        r.f = '{'1, 32'h1, 32'h1, 32'h1, 32'h0, 32'h0, 32'h0,
                32'h0001_0000, 32'h0001_0000, 32'h0001_0000};
        tbl.insert(tbl.size(), r);
        r.f = '{32'h0000_0001, 32'h0000_0100, 32'h0000_0200, 32'h0000_0300,
                32'hFFFF_0000, 32'h0001_0000, 32'h8000_0000,
                32'h8000_0000, 32'h7FFF_FFFF, 32'h0};
        tbl.insert(tbl.size(), r);
        r.f = '{32'h0002_0000, 32'h0002_0000, 32'h0000_0000, 32'h0002_0000,
                32'h0000_8000, 32'hFFFF_8000, 32'h0000_0001,
                32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF};
        tbl.insert(tbl.size(), r);
        r.f = '{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA};
        tbl.insert(tbl.size(), r);
        r.f = '{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555};
        tbl.insert(tbl.size(), r);

        foreach (tbl[i])
        begin
            want.energy = tbl[i].energy;
            want.degen  = tbl[i].degen;
            want.sat    = tbl[i].sat;
            push_expect(tbl[i].f, tbl[i].typed, want);
            send_face(tbl[i].f);
        end

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 51 : 0;
            recv_idle_pct = (phase == 0) ? 51 : (phase == 1) ? 36 : 0;
            for (int n = 0; n < 215; n++)
            begin
                // long receiver hold-off while faces keep coming
                if (phase == 2 && n == 20)
                    hold_req = 1'b1;
                // sender pauses until the pipeline drains
                if (phase == 1 && n == 100)
                begin
                    face.valid <= 1'b0;
                    guard = 0;
                    do
                    begin
                        @(negedge clk);
                        guard++;
                    end
                    while (energy_q.size() != 0 && guard < 100000);
                end
                // runs without gaps on either side for the rest of the first phase
                if (phase == 0 && n == 150)
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                f = rnd_face();
                want = '{0, 0, 0};
                push_expect(f, 1'b0, want);
                send_face(f);
            end
        end

        face.valid <= 1'b0;
        recv_idle_pct = 0;
        guard = 0;
        do
        begin
            @(negedge clk);
            guard++;
        end
        while (energy_q.size() != 0 && guard < 200000);
        if (energy_q.size() != 0)
            report("results never arrived", 64'(energy_q.size()), 64'd0);
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

FILE: sim.f
sv/fhse_pkg.sv
sv/fhse_if.sv
sv/fhse_div.sv
sv/fhse_mul.sv
sv/face_hencky_strain_energy.sv
sv/fhse_chk.sv
bench/tb_top.sv
